@@ rtl/bas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary-angle sine/cosine and vector argument: shared definitions
// Types of the pipeline lanes and results, and the elaboration-time functions
// that build the CORDIC arctangent entries and the inverse gain.
// ----------------------------------------------------------------------------
package bas_pkg;

   // Internal datapath width of x, y and z.
   localparam int DW = 64;
   // Width of every result field.
   localparam int OW = 32;
   // Pi scaled by 2^61, rounded to 64 bits.
   localparam logic [63:0] PI_61 = 64'h6487_ED51_10B4_611B;

   // Operation carried in the request beat.
   typedef enum logic {
      OP_SINCOS = 1'b0,
      OP_ATAN2  = 1'b1
   } op_type;

   // One item as it travels through the pipeline.
   typedef struct packed {
      op_type        op;       // Operation: sine/cosine or argument.
      logic [1:0]    quad;     // Quadrant of the angle, sine/cosine only.
      logic          zero;     // Zero vector, argument only.
      logic          off_en;   // Left half plane, argument only.
      logic          off_neg;  // Offset is minus half a turn.
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic [DW-1:0] z;
   } lane_type;

   // One finished result.
   typedef struct packed {
      logic [OW-1:0] ang_v;
      logic [OW-1:0] sin_v;
      logic [OW-1:0] cos_v;
   } result_type;

   // Restoring division, evaluated at elaboration only.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den,
                                          input logic want_rem);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return want_rem ? rem[63:0] : quo;
   endfunction

   // Arctangent of 2^-idx with half a turn equal to 2^62, truncated.
   function automatic logic [63:0] atan_entry(input int idx);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] num;
      logic [63:0] r;
      logic [63:0] q;
      int          k;
      int          odd;
      int          sh;
      logic        done;
      sum  = '0;
      done = 1'b0;
      r    = '0;
      q    = '0;
      if (idx == 0) begin
         q = 64'h1 << 60;
      end else begin
         // Alternating series of atan at 2^-62 radians.
         for (k = 0; k < 32; k++) begin
            odd = 2 * k + 1;
            sh  = idx * odd;
            if (!done) begin
               if (sh >= 63) begin
                  done = 1'b1;
               end else begin
                  num  = 64'h4000_0000_0000_0000 >> sh;
                  term = udiv64(num, 64'(odd), 1'b0);
                  if (term == 64'h0) begin
                     done = 1'b1;
                  end else if (k[0]) begin
                     sum = sum - term;
                  end else begin
                     sum = sum + term;
                  end
               end
            end
         end
         // Divide by pi * 2^61 to turn radians into binary angle units.
         r = sum;
         for (k = 0; k < 61; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= PI_61) begin
               r    = r - PI_61;
               q[0] = 1'b1;
            end
         end
      end
      return q;
   endfunction

   // Integer square root, evaluated at elaboration only.
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      int          j;
      v    = val;
      res  = '0;
      bitv = 64'h1 << 62;
      for (j = 0; j < 32; j++) begin
         if (bitv > v) begin
            bitv = bitv >> 2;
         end
      end
      for (j = 0; j < 32; j++) begin
         if (bitv != 64'h0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // Inverse CORDIC gain of n stages with 60 fraction bits, truncated.
   function automatic logic [63:0] inv_gain(input int n);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] q1;
      logic [63:0] r1;
      int          i;
      p = 64'h1 << 63;
      for (i = 1; i < n; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      s = isqrt64(p);
      if (s == 64'h0) begin
         s = 64'h1;
      end
      q1 = udiv64(64'h1 << 63, s, 1'b0);
      r1 = udiv64(64'h1 << 63, s, 1'b1);
      return (q1 << 28) + udiv64(r1 << 28, s, 1'b0);
   endfunction

endpackage

@@ rtl/bas_pre.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input stage
// Decodes the operation and loads the start vector and angle of the CORDIC.
// ----------------------------------------------------------------------------
module bas_pre #(
   parameter int STAGES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic              op,
   input  logic [31:0]       angle_val,
   input  logic [31:0]       x_val,
   input  logic [31:0]       y_val,
   output logic              out_vld,
   output bas_pkg::lane_type out_lane
);

   localparam logic [63:0] INV_GAIN = bas_pkg::inv_gain(STAGES);

   logic              vld_ff;
   bas_pkg::lane_type lane_ff;
   bas_pkg::lane_type lane_in;
   logic [32:0]       xs;
   logic [32:0]       ys;
   logic              left;

   // Fold the left half plane onto the right one by a half turn.
   always_comb begin
      left = x_val[31];
      xs   = {x_val[31], x_val};
      ys   = {y_val[31], y_val};
      if (left) begin
         xs = 33'h0 - xs;
         ys = 33'h0 - ys;
      end
   end

   // Start values for rotation or vectoring.
   always_comb begin
      lane_in         = '0;
      lane_in.op      = bas_pkg::op_type'(op);
      if (op == bas_pkg::OP_SINCOS) begin
         lane_in.quad = angle_val[30:29];
         lane_in.x    = INV_GAIN;
         lane_in.y    = 64'h0;
         lane_in.z    = {3'b000, angle_val[28:0], 32'h0};
      end else begin
         lane_in.zero    = (x_val == 32'h0) && (y_val == 32'h0);
         lane_in.off_en  = left;
         lane_in.off_neg = y_val[31];
         lane_in.x       = {{3{xs[32]}}, xs, 28'h0};
         lane_in.y       = {{3{ys[32]}}, ys, 28'h0};
         lane_in.z       = 64'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_lane = lane_ff;

endmodule

@@ rtl/bas_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One iteration with a fixed shift and arctangent, shared by rotation mode
// (steer z toward zero) and vectoring mode (steer y toward zero).
// ----------------------------------------------------------------------------
module bas_stage #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  bas_pkg::lane_type in_lane,
   output logic              out_vld,
   output bas_pkg::lane_type out_lane
);

   localparam logic [63:0] ATAN = bas_pkg::atan_entry(IDX);

   logic              vld_ff;
   bas_pkg::lane_type lane_ff;
   bas_pkg::lane_type lane_in;
   logic [63:0]       dx;
   logic [63:0]       dy;
   logic              pos;

   // Positive rotation when z is not negative (rotation) or y is negative
   // (vectoring).
   always_comb begin
      dx      = 64'($signed(in_lane.y) >>> IDX);
      dy      = 64'($signed(in_lane.x) >>> IDX);
      pos     = (in_lane.op == bas_pkg::OP_ATAN2) ? in_lane.y[63] : ~in_lane.z[63];
      lane_in = in_lane;
      if (pos) begin
         lane_in.x = in_lane.x - dx;
         lane_in.y = in_lane.y + dy;
         lane_in.z = in_lane.z - ATAN;
      end else begin
         lane_in.x = in_lane.x + dx;
         lane_in.y = in_lane.y - dy;
         lane_in.z = in_lane.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_lane = lane_ff;

endmodule

@@ rtl/bas_post.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output formatting
// Two stages: rounding to the output scale, then saturation, quadrant
// mapping, half-plane offset and clearing of unused fields.
// ----------------------------------------------------------------------------
module bas_post #(
   parameter int FRAC_BITS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  bas_pkg::lane_type   in_lane,
   output logic                out_vld,
   output bas_pkg::result_type out_res
);

   localparam int SH = 60 - FRAC_BITS;
   localparam int RW = FRAC_BITS + 4;
   localparam int CW = FRAC_BITS + 2;
   localparam logic [63:0] HALF_LSB = 64'h1 << (SH - 1);
   localparam logic signed [RW-1:0] LIM_POS = RW'(64'h1 << FRAC_BITS);
   localparam logic signed [RW-1:0] LIM_NEG = -LIM_POS;
   localparam logic signed [32:0] HALF_TURN = 33'sh0_4000_0000;

   logic                p1_vld_ff;
   logic                p1_op_ff;
   logic [1:0]          p1_quad_ff;
   logic                p1_zero_ff;
   logic                p1_off_en_ff;
   logic                p1_off_neg_ff;
   logic [RW-1:0]       p1_x_ff;
   logic [RW-1:0]       p1_y_ff;
   logic [31:0]         p1_z_ff;
   logic [RW-1:0]       p1_x_in;
   logic [RW-1:0]       p1_y_in;
   logic [31:0]         p1_z_in;
   logic [63:0]         x_sh;
   logic [63:0]         y_sh;
   logic [63:0]         z_sum;

   logic                p2_vld_ff;
   bas_pkg::result_type p2_res_ff;
   bas_pkg::result_type p2_res_in;
   logic signed [RW-1:0] x_cl;
   logic signed [RW-1:0] y_cl;
   logic signed [CW-1:0] x_nr;
   logic signed [CW-1:0] y_nr;
   logic signed [31:0]  x_w;
   logic signed [31:0]  y_w;
   logic signed [32:0]  off;
   logic signed [32:0]  a_sum;
   logic signed [32:0]  a_cl;

   // Round half up from 60 fraction bits, and z to binary-angle units.
   always_comb begin
      x_sh    = 64'($signed(in_lane.x + HALF_LSB) >>> SH);
      y_sh    = 64'($signed(in_lane.y + HALF_LSB) >>> SH);
      z_sum   = in_lane.z + 64'h8000_0000;
      p1_x_in = x_sh[RW-1:0];
      p1_y_in = y_sh[RW-1:0];
      p1_z_in = z_sum[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_op_ff      <= in_lane.op;
         p1_quad_ff    <= in_lane.quad;
         p1_zero_ff    <= in_lane.zero;
         p1_off_en_ff  <= in_lane.off_en;
         p1_off_neg_ff <= in_lane.off_neg;
         p1_x_ff       <= p1_x_in;
         p1_y_ff       <= p1_y_in;
         p1_z_ff       <= p1_z_in;
      end
   end

   // Saturate the components to plus or minus one.
   always_comb begin
      x_cl = $signed(p1_x_ff);
      y_cl = $signed(p1_y_ff);
      if (x_cl > LIM_POS) begin
         x_cl = LIM_POS;
      end else if (x_cl < LIM_NEG) begin
         x_cl = LIM_NEG;
      end
      if (y_cl > LIM_POS) begin
         y_cl = LIM_POS;
      end else if (y_cl < LIM_NEG) begin
         y_cl = LIM_NEG;
      end
      x_nr = x_cl[CW-1:0];
      y_nr = y_cl[CW-1:0];
      x_w  = 32'(x_nr);
      y_w  = 32'(y_nr);
   end

   // Add the half-plane offset to the argument and saturate it.
   always_comb begin
      if (!p1_off_en_ff) begin
         off = 33'sh0;
      end else if (p1_off_neg_ff) begin
         off = -HALF_TURN;
      end else begin
         off = HALF_TURN;
      end
      a_sum = 33'($signed(p1_z_ff)) + off;
      if (a_sum > HALF_TURN) begin
         a_cl = HALF_TURN;
      end else if (a_sum < -HALF_TURN) begin
         a_cl = -HALF_TURN;
      end else begin
         a_cl = a_sum;
      end
   end

   // Map the quadrant by swapping and negating, and clear unused fields.
   always_comb begin
      p2_res_in = '0;
      if (p1_op_ff == bas_pkg::OP_ATAN2) begin
         p2_res_in.ang_v = p1_zero_ff ? 32'h0 : a_cl[31:0];
      end else begin
         case (p1_quad_ff)
            2'd0: begin
               p2_res_in.cos_v = x_w;
               p2_res_in.sin_v = y_w;
            end
            2'd1: begin
               p2_res_in.cos_v = -y_w;
               p2_res_in.sin_v = x_w;
            end
            2'd2: begin
               p2_res_in.cos_v = -x_w;
               p2_res_in.sin_v = -y_w;
            end
            default: begin
               p2_res_in.cos_v = y_w;
               p2_res_in.sin_v = -x_w;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_res_ff <= p2_res_in;
      end
   end

   assign out_vld = p2_vld_ff;
   assign out_res = p2_res_ff;

endmodule

@@ rtl/bas_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register with skid slot
// Holds the result beat on the master side and parks one more beat, so the
// pipeline keeps moving while a result waits. The stall comes from a flop.
// ----------------------------------------------------------------------------
module bas_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_vld,
   input  bas_pkg::result_type push_res,
   output logic                en,
   output logic                rsp_vld,
   input  logic                rsp_rdy,
   output bas_pkg::result_type rsp_res
);

   logic                head_vld_ff;
   logic                head_vld_in;
   bas_pkg::result_type head_res_ff;
   bas_pkg::result_type head_res_in;
   logic                skid_vld_ff;
   logic                skid_vld_in;
   bas_pkg::result_type skid_res_ff;
   bas_pkg::result_type skid_res_in;
   logic                push;
   logic                head_free;

   // The pipeline advances whenever the skid slot is empty.
   assign en        = ~skid_vld_ff;
   assign push      = push_vld & en;
   assign head_free = ~head_vld_ff | rsp_rdy;

   // Head refills from the skid slot first, then from the pipeline.
   always_comb begin
      head_vld_in = head_vld_ff;
      head_res_in = head_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (head_free) begin
         head_vld_in = skid_vld_ff | push;
         head_res_in = skid_vld_ff ? skid_res_ff : push_res;
         skid_vld_in = 1'b0;
      end else if (push) begin
         skid_vld_in = 1'b1;
         skid_res_in = push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_res_ff <= head_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_vld = head_vld_ff;
   assign rsp_res = head_res_ff;

endmodule

@@ rtl/binary_angle_sincos_atan2.sv @@
`timescale 1ns / 1ps
// Stages from an accepted request beat to its response beat: input stage, STAGES
// micro-rotations, two output stages, output reg. Throughput: one beat per cycle
// while the skid slot is empty, set by the one-iteration-per-stage CORDIC.
// Reset clears every valid bit of the pipeline and the output register.
// ----------------------------------------------------------------------------
// Binary-angle sine/cosine and vector argument
// Pipelined CORDIC: rotation mode for cosine and sine of a binary angle,
// vectoring mode for the argument of (x, y), one micro-rotation per stage.
// ----------------------------------------------------------------------------
module binary_angle_sincos_atan2 #(
   parameter int STAGES    = 32,
   parameter int FRAC_BITS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // angle_in[31:0], x_in[63:32], y_in[95:64]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // cos_out[31:0], sin_out[63:32], angle_out[95:64]
);

   localparam logic signed [31:0] ONE_FX = 32'(64'h1 << FRAC_BITS);
   localparam logic signed [31:0] HALF_TURN = 32'sh4000_0000;

   logic                pipe_en;
   logic [STAGES:0]     vld_s;
   bas_pkg::lane_type   lane_s [0:STAGES];
   logic                post_vld;
   bas_pkg::result_type post_res;
   bas_pkg::result_type rsp_res;

   assign req_tready = pipe_en;

   // Operation decode and start values.
   bas_pre #(
      .STAGES (STAGES)
   ) u_pre (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_vld    (req_tvalid),
      .op        (req_tuser),
      .angle_val (req_tdata[31:0]),
      .x_val     (req_tdata[63:32]),
      .y_val     (req_tdata[95:64]),
      .out_vld   (vld_s[0]),
      .out_lane  (lane_s[0])
   );

   // Chain of micro-rotation stages.
   for (genvar g = 0; g < STAGES; g++) begin : g_cordic
      bas_stage #(
         .IDX (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .in_vld   (vld_s[g]),
         .in_lane  (lane_s[g]),
         .out_vld  (vld_s[g+1]),
         .out_lane (lane_s[g+1])
      );
   end

   // Rounding, saturation and quadrant mapping.
   bas_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .in_vld  (vld_s[STAGES]),
      .in_lane (lane_s[STAGES]),
      .out_vld (post_vld),
      .out_res (post_res)
   );

   // Output register and skid slot.
   bas_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push_vld (post_vld),
      .push_res (post_res),
      .en       (pipe_en),
      .rsp_vld  (rsp_tvalid),
      .rsp_rdy  (rsp_tready),
      .rsp_res  (rsp_res)
   );

   assign rsp_tdata = {rsp_res.ang_v, rsp_res.sin_v, rsp_res.cos_v};

   // A stalled pipeline keeps its last finished result in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!pipe_en && post_vld) |=> (post_vld && $stable(post_res)))
      else $error("pipeline result changed during a stall");

   // Cosine and sine never leave the range of plus or minus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_res.cos_v) <= ONE_FX && $signed(rsp_res.cos_v) >= -ONE_FX
                   && $signed(rsp_res.sin_v) <= ONE_FX && $signed(rsp_res.sin_v) >= -ONE_FX))
      else $error("cosine or sine out of range");

   // The argument never leaves plus or minus half a turn.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_res.ang_v) <= HALF_TURN
                   && $signed(rsp_res.ang_v) >= -HALF_TURN))
      else $error("argument out of range");

endmodule

@@ bench/binary_angle_sincos_atan2_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for binary_angle_sincos_atan2
// Drives sine/cosine and vector-argument beats through the CORDIC pipeline.
// Each result is checked field by field against a bit-exact predictor. The
// run covers directed corner cases, then random beats under receiver stalls,
// sender gaps and full rate.
// ----------------------------------------------------------------------------
module binary_angle_sincos_atan2_tb;

   localparam int STAGES     = 32;
   localparam int FRAC_BITS  = 30;
   localparam int TIMEOUT_NS = 3_000_000;
   // Pi scaled by 2^61.
   localparam longint unsigned PI_Q61 = 64'h6487_ED51_10B4_611B;
   localparam longint HALF_TURN = 64'sd1073741824;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;    // angle_in[31:0], x_in[63:32], y_in[95:64]
   logic        req_tuser  = 1'b0;  // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;          // cos_out[31:0], sin_out[63:32], angle_out[95:64]

   // Arctangent steps (half a turn = 2^62) and the start length of rotation.
   longint atan_steps [STAGES];
   longint rotate_start;

   bas_pkg::result_type trig_results_due [$];

   int send_idle_pct = 9;
   int recv_idle_pct = 66;
   int n_sincos      = 0;
   int n_atan2       = 0;
   int n_checked     = 0;
   int n_errors      = 0;

   binary_angle_sincos_atan2 #(
      .STAGES   (STAGES),
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Build the arctangent steps and the inverse gain in 64-bit integers.
   initial begin : build_constants
      longint unsigned sum, term, rem, quo, p, v, root, bitv, q1, r1;
      int i, k, sh;
      atan_steps[0] = longint'(64'h1000_0000_0000_0000);
      for (i = 1; i < STAGES; i++) begin
         // Alternating series of atan(2^-i) at 2^-62 radians.
         sum = 0;
         for (k = 0; k < 32; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 63) break;
            term = (64'h4000_0000_0000_0000 >> sh) / 64'(2 * k + 1);
            if (term == 0) break;
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         // Long division by pi to get binary-angle units.
         rem = sum;
         quo = 0;
         for (k = 0; k < 61; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= PI_Q61) begin
               rem = rem - PI_Q61;
               quo = quo | 64'h1;
            end
         end
         atan_steps[i] = longint'(quo);
      end
      // Squared gain product, its square root, then 2^63 / root at 60 bits.
      p = 64'h8000_0000_0000_0000;
      for (i = 1; i < STAGES; i++) begin
         if (2 * i < 64) p = p + (p >> (2 * i));
      end
      v    = p;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (root == 0) root = 1;
      q1 = 64'h8000_0000_0000_0000 / root;
      r1 = 64'h8000_0000_0000_0000 % root;
      rotate_start = longint'((q1 << 28) + ((r1 << 28) / root));
   end

   // Round half up from 60 fraction bits to FRAC_BITS and saturate.
   function automatic longint to_frac_bits(longint v);
      longint r;
      longint lim;
      lim = longint'(1) <<< FRAC_BITS;
      r   = (v + (longint'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   // Expected result of one beat: rotation mode for sine/cosine, vectoring
   // for the argument.
   function automatic bas_pkg::result_type cordic_trig(bas_pkg::op_type op,
                                                       logic [31:0] angle,
                                                       logic [31:0] re, logic [31:0] im);
      bas_pkg::result_type r;
      longint x, y, z, dx, dy, xo, yo, c, s, off, a, xs, ys;
      int i;
      r = '0;
      if (op == bas_pkg::OP_SINCOS) begin
         // Residual below a quarter turn, scaled by 2^32.
         x = rotate_start;
         y = 0;
         z = longint'({3'b000, angle[28:0], 32'h0});
         for (i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_steps[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_steps[i];
            end
         end
         xo = to_frac_bits(x);
         yo = to_frac_bits(y);
         // The quadrant swaps and negates the rotated components.
         case (angle[30:29])
            2'd0: begin
               c = xo;
               s = yo;
            end
            2'd1: begin
               c = -yo;
               s = xo;
            end
            2'd2: begin
               c = -xo;
               s = -yo;
            end
            default: begin
               c = yo;
               s = -xo;
            end
         endcase
         r.cos_v = 32'(c);
         r.sin_v = 32'(s);
      end else begin
         xs = longint'(signed'(re));
         ys = longint'(signed'(im));
         // The zero vector keeps angle 0.
         if (xs != 0 || ys != 0) begin
            off = 0;
            // Left half plane: turn by half a turn first.
            if (xs < 0) begin
               off = (ys >= 0) ? HALF_TURN : -HALF_TURN;
               xs  = -xs;
               ys  = -ys;
            end
            x = xs <<< 28;
            y = ys <<< 28;
            z = 0;
            for (i = 0; i < STAGES; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  z = z + atan_steps[i];
               end else begin
                  x = x - dx;
                  y = y + dy;
                  z = z - atan_steps[i];
               end
            end
            a = ((z + 64'sd2147483648) >>> 32) + off;
            if (a > HALF_TURN) a = HALF_TURN;
            if (a < -HALF_TURN) a = -HALF_TURN;
            r.ang_v = 32'(a);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
               $time, what, n_checked, signed'(got), signed'(want));
   endtask

   // Send one request beat, with random gaps before it.
   task automatic send_item(bas_pkg::op_type op, logic [31:0] angle, logic [31:0] re,
                            logic [31:0] im);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {im, re, angle};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      trig_results_due.push_back(cordic_trig(op, angle, re, im));
      if (op == bas_pkg::OP_SINCOS) n_sincos++;
      else n_atan2++;
   endtask

   // Hold off the sender until every expected result has arrived.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (trig_results_due.size() != 0) @(posedge clock);
   endtask

   // Quadrant edges, wrap of the top bit and the extremes of the angle.
   task automatic test_sincos_directed();
      send_item(bas_pkg::OP_SINCOS, 32'h0000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h0000_0001, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h1000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h1FFF_FFFF, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h2000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h4000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h6000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h7FFF_FFFF, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h8000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'hA000_0000, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'hFFFF_FFFF, $urandom, $urandom);
      send_item(bas_pkg::OP_SINCOS, 32'h5555_5555, $urandom, $urandom);
      wait_for_results();
   endtask

   // Zero vector, the axes, the left half plane and the extreme components.
   task automatic test_atan2_directed();
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h0000_0000, 32'h0000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h0000_0001, 32'h0000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h0000_0000, 32'h0000_0001);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h8000_0000, 32'h8000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h8000_0000, 32'h0000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h0000_0000, 32'h8000_0000);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(bas_pkg::OP_ATAN2, $urandom, 32'h7FFF_FFFF, 32'h8000_0000);
      wait_for_results();
   endtask

   // Random beats of both operations, shaped toward the corners.
   task automatic random_items(int count);
      logic [31:0] angle, re, im;
      bas_pkg::op_type op;
      int i, k;
      for (i = 0; i < count; i++) begin
         angle = $urandom;
         re    = $urandom;
         im    = $urandom;
         op    = bas_pkg::op_type'($urandom_range(1));
         case ($urandom_range(7))
            0: angle = {angle[31:29], 29'h0} + 32'($urandom_range(4)) - 32'd2;
            1: begin
               re = $urandom_range(16) - 8;
               im = $urandom_range(16) - 8;
            end
            2: begin
               if ($urandom_range(1) == 1) re = '0;
               else im = '0;
            end
            3: begin
               re = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               if ($urandom_range(1) == 1) im = re;
            end
            4: begin
               k  = $urandom_range(31);
               re = signed'(re) >>> k;
               im = signed'(im) >>> k;
            end
            default: ;
         endcase
         send_item(op, angle, re, im);
      end
      wait_for_results();
   endtask

   task automatic test_random_slow_receiver();
      send_idle_pct = 9;
      recv_idle_pct = 66;
      random_items(520);
   endtask

   task automatic test_random_slow_sender();
      send_idle_pct = 66;
      recv_idle_pct = 9;
      random_items(520);
   endtask

   task automatic test_random_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(520);
   endtask

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare every response beat with the oldest expectation.
   always @(posedge clock) begin : check_results
      bas_pkg::result_type got;
      bas_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (trig_results_due.size() == 0) begin
            report_mismatch("unexpected beat, angle_out", got.ang_v, '0);
         end else begin
            want = trig_results_due.pop_front();
            n_checked++;
            if (got.cos_v !== want.cos_v) report_mismatch("cos_out", got.cos_v, want.cos_v);
            if (got.sin_v !== want.sin_v) report_mismatch("sin_out", got.sin_v, want.sin_v);
            if (got.ang_v !== want.ang_v) report_mismatch("angle_out", got.ang_v, want.ang_v);
         end
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_sincos_directed();
      test_atan2_directed();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_full_rate();
      repeat (STAGES + 8) @(posedge clock);
      $display("Checked %0d results from %0d sine/cosine and %0d argument beats.",
               n_checked, n_sincos, n_atan2);
      $display("Stalls ran on the receiver side, then the sender side, then none.");
      if (n_errors == 0 && trig_results_due.size() == 0) begin
         $display("binary_angle_sincos_atan2_tb passed");
      end else begin
         $display("binary_angle_sincos_atan2_tb failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding.", trig_results_due.size());
      $display("binary_angle_sincos_atan2_tb failed");
      $finish;
   end

endmodule
